/* sv/key_press_pattern_reader_macros.svh */
// Assertion macros used by the key press pattern reader RTL.
// Needs a clock named clk and an active-high reset named rst in scope.
`ifndef KEY_PRESS_PATTERN_READER_MACROS_SVH
`define KEY_PRESS_PATTERN_READER_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define KPR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kpr assertion failed");

// The consequent holds in the cycle after the antecedent.
`define KPR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kpr assertion failed");

`endif

/* sv/kpr_pkg.sv */
// Package for the key press pattern reader: payload and config types,
// register indexes, reset values and beep codes. No dependencies.
package kpr_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_DEBOUNCE = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SHORT    = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_BEEP     = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_LONG     = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP      = 3'd4;

  localparam logic [7:0]  DEBOUNCE_RST = 8'd2;
  localparam logic [15:0] SHORT_RST    = 16'd30;
  localparam logic [15:0] BEEP_RST     = 16'd200;
  localparam logic [15:0] LONG_RST     = 16'd280;
  localparam logic [15:0] GAP_RST      = 16'd50;

  localparam logic [1:0] BEEP_NONE  = 2'd0;
  localparam logic [1:0] BEEP_START = 2'd1;
  localparam logic [1:0] BEEP_STOP  = 2'd2;

  localparam logic [7:0] PRESS_BIT = 8'h01;

  typedef struct packed {
    logic        pin_level;
    logic [31:0] time_now;
  } kpr_poll_t;

  typedef struct packed {
    logic       code_ready;
    logic [7:0] press_code;
    logic       long_press_event;
    logic [1:0] beep_command;
  } kpr_result_t;

  typedef struct packed {
    logic [7:0]  debounce_ticks;
    logic [15:0] short_window_ticks;
    logic [15:0] beep_after_ticks;
    logic [15:0] long_after_ticks;
    logic [15:0] gap_window_ticks;
  } kpr_cfg_t;

endpackage

/* sv/kpr_cfg_regs.sv */
// Configuration register file of the key press pattern reader.
// Depends on kpr_pkg.
module kpr_cfg_regs
  import kpr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output kpr_cfg_t               cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_ticks     <= DEBOUNCE_RST;
      cfg.short_window_ticks <= SHORT_RST;
      cfg.beep_after_ticks   <= BEEP_RST;
      cfg.long_after_ticks   <= LONG_RST;
      cfg.gap_window_ticks   <= GAP_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_DEBOUNCE: cfg.debounce_ticks     <= cfg_data[7:0];
        REG_SHORT:    cfg.short_window_ticks <= cfg_data;
        REG_BEEP:     cfg.beep_after_ticks   <= cfg_data;
        REG_LONG:     cfg.long_after_ticks   <= cfg_data;
        REG_GAP:      cfg.gap_window_ticks   <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

/* sv/kpr_debounce.sv */
// One debouncer: starts timing on the target level, confirms it after the settle time.
// Self-contained; needs no package.
module kpr_debounce (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  logic        target,
  input  logic        pin_level,
  input  logic [31:0] time_now,
  input  logic [7:0]  debounce_ticks,
  output logic        seen
);

  logic        armed;
  logic        armed_next;
  logic [31:0] mark;
  logic [31:0] mark_next;
  logic [31:0] elapsed;
  logic        at_level;

  assign elapsed  = time_now - mark;
  assign at_level = (pin_level == target);

  always_comb begin
    armed_next = armed;
    mark_next  = mark;
    seen       = 1'b0;
    if (armed && at_level) begin
      armed_next = 1'b0;
      mark_next  = time_now;
    end else if (!armed && (elapsed >= {24'd0, debounce_ticks})) begin
      armed_next = 1'b1;
      seen       = at_level;
    end
  end

  // The state only advances on polls where the phase machine consults it.
  always_ff @(posedge clk) begin
    if (rst) begin
      armed <= 1'b1;
      mark  <= '0;
    end else if (step) begin
      armed <= armed_next;
      mark  <= mark_next;
    end
  end

endmodule

/* sv/kpr_fsm.sv */
// Phase machine of the key press pattern reader with its two debouncers.
// Depends on kpr_pkg, kpr_debounce and the assertion macro header.
`include "key_press_pattern_reader_macros.svh"

module kpr_fsm
  import kpr_pkg::*;
#(
  parameter int MAX_PRESSES = 4
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        step,
  input  kpr_poll_t   poll,
  input  kpr_cfg_t    cfg,
  output kpr_result_t res
);

  typedef enum logic [2:0] {
    PH_INIT    = 3'd0,
    PH_WAIT    = 3'd1,
    PH_HELD    = 3'd2,
    PH_COUNTED = 3'd3,
    PH_GAP     = 3'd4
  } phase_t;

  phase_t      phase;
  phase_t      phase_next;
  logic [7:0]  pattern;
  logic [7:0]  pattern_next;
  logic [7:0]  press_count;
  logic [7:0]  press_count_next;
  logic [31:0] window_mark;
  logic [31:0] window_mark_next;
  logic [31:0] el;
  logic        down_use;
  logic        up_use;
  logic        down_seen;
  logic        up_seen;

  assign el = poll.time_now - window_mark;

  kpr_debounce u_down (
    .clk            (clk),
    .rst            (rst),
    .step           (step && down_use),
    .target         (1'b0),
    .pin_level      (poll.pin_level),
    .time_now       (poll.time_now),
    .debounce_ticks (cfg.debounce_ticks),
    .seen           (down_seen)
  );

  kpr_debounce u_up (
    .clk            (clk),
    .rst            (rst),
    .step           (step && up_use),
    .target         (1'b1),
    .pin_level      (poll.pin_level),
    .time_now       (poll.time_now),
    .debounce_ticks (cfg.debounce_ticks),
    .seen           (up_seen)
  );

  always_comb begin
    phase_next       = phase;
    pattern_next     = pattern;
    press_count_next = press_count;
    window_mark_next = window_mark;
    down_use         = 1'b0;
    up_use           = 1'b0;
    res.code_ready       = 1'b0;
    res.long_press_event = 1'b0;
    res.beep_command     = BEEP_NONE;
    unique case (phase)
      PH_INIT: begin
        pattern_next     = '0;
        press_count_next = '0;
        phase_next       = PH_WAIT;
      end
      PH_WAIT: begin
        down_use = 1'b1;
        if (down_seen) begin
          pattern_next     = pattern | PRESS_BIT;
          window_mark_next = poll.time_now;
          phase_next       = PH_HELD;
        end
      end
      PH_HELD: begin
        if (el < {16'd0, cfg.short_window_ticks}) begin
          up_use = 1'b1;
          if (up_seen) begin
            pattern_next = {pattern[6:0], 1'b0};
            phase_next   = PH_COUNTED;
          end
        end else if (el > {16'd0, cfg.beep_after_ticks}) begin
          // Between the beep and long limits the release watcher is paused.
          res.beep_command = BEEP_START;
          if (el > {16'd0, cfg.long_after_ticks}) begin
            res.beep_command = BEEP_STOP;
            up_use = 1'b1;
            if (up_seen) begin
              pattern_next         = {pattern[6:0], 1'b1};
              res.long_press_event = 1'b1;
              res.code_ready       = 1'b1;
              phase_next           = PH_INIT;
            end
          end
        end else begin
          up_use = 1'b1;
          if (up_seen) begin
            pattern_next = {pattern[6:0], 1'b1};
            phase_next   = PH_COUNTED;
          end
        end
      end
      PH_COUNTED: begin
        press_count_next = press_count + 8'd1;
        if (press_count_next == 8'(MAX_PRESSES)) begin
          res.code_ready = 1'b1;
          phase_next     = PH_INIT;
        end else begin
          window_mark_next = poll.time_now;
          phase_next       = PH_GAP;
        end
      end
      PH_GAP: begin
        if (el <= {16'd0, cfg.gap_window_ticks}) begin
          down_use = 1'b1;
          if (down_seen) begin
            window_mark_next = poll.time_now;
            phase_next       = PH_HELD;
          end
        end else begin
          res.code_ready = 1'b1;
          phase_next     = PH_INIT;
        end
      end
      default: ;
    endcase
    res.press_code = pattern_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_INIT;
      pattern     <= '0;
      press_count <= '0;
      window_mark <= '0;
    end else if (step) begin
      phase       <= phase_next;
      pattern     <= pattern_next;
      press_count <= press_count_next;
      window_mark <= window_mark_next;
    end
  end

  `KPR_ASSERT_NOW(a_long_completes, res.long_press_event, res.code_ready)
  `KPR_ASSERT_NEXT(a_ready_restarts, step && res.code_ready, phase == PH_INIT)
  `KPR_ASSERT_NEXT(a_init_to_wait, step && phase == PH_INIT, phase == PH_WAIT)
  `KPR_ASSERT_NOW(a_beep_only_held, res.beep_command != BEEP_NONE, phase == PH_HELD)

endmodule

/* sv/key_press_pattern_reader.sv */
// Top level of the key press pattern reader: poll register, phase machine,
// result register. Depends on kpr_pkg, kpr_cfg_regs and kpr_fsm.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   poll     | poll_valid, poll_stall, poll         | in
//   result   | result_valid, result_stall, result   | out
//   config   | cfg_write, cfg_index, cfg_data       | in
//
// Each poll gives exactly one result, via the poll and result registers.
// One poll is taken every cycle while poll_stall is low; the phase registers
// close their loop without passing through the poll register.
// Reset (synchronous) resets all registers but the poll_q and result data.
// A stalled result holds the poll register, which then stalls the poll side.
module key_press_pattern_reader
  import kpr_pkg::*;
#(
  parameter int MAX_PRESSES = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   poll_valid,
  output logic                   poll_stall,
  input  kpr_poll_t              poll,
  output logic                   result_valid,
  input  logic                   result_stall,
  output kpr_result_t            result,
  input  logic                   cfg_write,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  kpr_cfg_t    cfg;
  kpr_poll_t   poll_q;
  logic        poll_q_valid;
  logic        out_open;
  logic        fire;
  kpr_result_t fsm_res;

  assign out_open   = !result_valid || !result_stall;
  assign fire       = poll_q_valid && out_open;
  assign poll_stall = poll_q_valid && !out_open;

  kpr_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  kpr_fsm #(
    .MAX_PRESSES (MAX_PRESSES)
  ) u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (fire),
    .poll (poll_q),
    .cfg  (cfg),
    .res  (fsm_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      poll_q_valid <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (!poll_stall) begin
        poll_q_valid <= poll_valid;
      end
      if (out_open) begin
        result_valid <= poll_q_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (poll_valid && !poll_stall) begin
      poll_q <= poll;
    end
    if (fire) begin
      result <= fsm_res;
    end
  end

endmodule
